[design/ghp_pkg.sv]
// Package for the generational handle pool.
// Holds operation codes, register indexes and the slot memory entry type.
// No dependencies.
`default_nettype none

package ghp_pkg;

	// Operation carried by the kind field of an input item.
	typedef enum logic [1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_POOL_ID      = 2'd0;
	localparam logic [1:0] REG_ELEMENT_SIZE = 2'd1;

	// Fixed field widths of the interface.
	localparam int POOL_W  = 8;
	localparam int HSLOT_W = 10;
	localparam int VER_W   = 16;
	localparam int ESIZE_W = 13;
	localparam int ADDR_W  = 22;
	localparam int CNT_W   = 11;
	localparam int CFG_W   = 13;

	// One entry of the slot memory: current version and live mark.
	typedef struct packed {
		logic [VER_W-1:0] version;
		logic             live;
	} slot_entry_t;

endpackage

`default_nettype wire

[design/generational_handle_pool_unit.sv]
// Generational handle pool: top level.
// Depends on ghp_pkg and ghp_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: allocate,
//   free or lookup, with a handle made of pool id, slot and version.
//   Output channel (out_valid/out_ready) returns one result item per input
//   item, in order: ok, slot, version, pool, address and the live and free
//   counts after the operation.
//   Configuration channel (cfg_valid/cfg_ready) writes pool_id (index 0) or
//   element_size (index 1); other indexes are ignored. It is always ready.
// Timing:
//   An item is held in stage 1 while the slot memory and free stack reads issued
//   at acceptance return; on completion the updated entry is written back and
//   the output register is loaded. A new item is taken only after the item in
//   stage 1 has completed, set by this read then write-back of the slot memory.
//   When the receiver stalls, the item in flight waits with its read data held,
//   and in_ready stays low until it moves into the output register.
// Reset:
//   All counters clear and the registers take pool_id -1 and element_size 1.
//   Slots at or above the fresh-slot count read as never used, so the memories
//   need no clearing pass and the block is ready right after reset.
`default_nettype none

module generational_handle_pool_unit #(
	parameter int SLOTS = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input item channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       kind,
	input  wire logic signed [ghp_pkg::POOL_W-1:0]  handle_pool,
	input  wire logic [ghp_pkg::HSLOT_W-1:0]      handle_slot,
	input  wire logic [ghp_pkg::VER_W-1:0]        handle_version,
	// Result item channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  ok,
	output logic [ghp_pkg::HSLOT_W-1:0]           slot,
	output logic [ghp_pkg::VER_W-1:0]             version,
	output logic signed [ghp_pkg::POOL_W-1:0]     pool,
	output logic [ghp_pkg::ADDR_W-1:0]            address,
	output logic [ghp_pkg::CNT_W-1:0]             live_count,
	output logic [ghp_pkg::CNT_W-1:0]             free_count,
	// Configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [ghp_pkg::CFG_W-1:0]        cfg_data
);

	import ghp_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int STK_W = VER_W + SW;
	localparam int ENT_W = $bits(slot_entry_t);

	// Configuration registers.
	logic signed [POOL_W-1:0] pool_id_q;
	logic [ESIZE_W-1:0]       element_size_q;

	// Pool counters.
	logic [CW-1:0] next_fresh_q;
	logic [CW-1:0] free_top_q;
	logic [CW-1:0] in_use_q;

	// Stage 1: item whose memory reads are in flight.
	logic                     valid_s1;
	logic [1:0]               kind_s1;
	logic [POOL_W-1:0]        hpool_s1;
	logic [HSLOT_W-1:0]       hslot_s1;
	logic [VER_W-1:0]         hver_s1;

	// Output register.
	logic                     out_valid_q;
	logic                     ok_q;
	logic [HSLOT_W-1:0]       slot_q;
	logic [VER_W-1:0]         version_q;
	logic [POOL_W-1:0]        pool_q;
	logic [ADDR_W-1:0]        address_q;
	logic [CW-1:0]            live_next;
	logic [CW-1:0]            free_next;
	logic [CW-1:0]            fresh_next;

	// Memory ports.
	logic              in_fire;
	logic              done_s1;
	logic              slot_wr_en;
	logic [SW-1:0]     slot_wr_addr;
	slot_entry_t       slot_wr_data;
	slot_entry_t       slot_rd_data;
	logic [ENT_W-1:0]  slot_rd_raw;
	logic              stk_wr_en;
	logic [SW-1:0]     stk_wr_addr;
	logic [STK_W-1:0]  stk_wr_data;
	logic [STK_W-1:0]  stk_rd_data;
	logic [SW-1:0]     stk_rd_addr;

	// Stage 1 results.
	logic                     res_ok;
	logic [HSLOT_W-1:0]       res_slot;
	logic [VER_W-1:0]         res_version;
	logic [POOL_W-1:0]        res_pool;
	logic [ADDR_W-1:0]        res_address;
	logic                     handle_good;
	logic                     entry_touched;
	logic                     cur_live;
	logic [VER_W-1:0]         cur_version;
	logic [VER_W-1:0]         bumped_version;
	logic [ESIZE_W+HSLOT_W-1:0] product;

	// Handshakes.
	assign in_ready  = !valid_s1;
	assign in_fire   = in_valid && in_ready;
	assign done_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_id_q      <= '1;
			element_size_q <= ESIZE_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POOL_ID:      pool_id_q      <= cfg_data[POOL_W-1:0];
				REG_ELEMENT_SIZE: element_size_q <= cfg_data[ESIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// The stack read always targets the top entry; it is used only for a pop.
	assign stk_rd_addr = SW'(free_top_q - CW'(1));

	// Slot state memory: version and live mark per slot.
	ghp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (slot_wr_en),
		.wr_addr(slot_wr_addr),
		.wr_data(slot_wr_data),
		.rd_en  (in_fire),
		.rd_addr(SW'(handle_slot)),
		.rd_data(slot_rd_raw)
	);
	assign slot_rd_data = slot_entry_t'(slot_rd_raw);

	// Free stack memory: each entry keeps the slot and its bumped version.
	ghp_ram #(
		.WIDTH(STK_W),
		.DEPTH(SLOTS)
	) u_stack_ram (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(stk_wr_addr),
		.wr_data(stk_wr_data),
		.rd_en  (in_fire),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	// Stage 1 capture of the accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind;
			hpool_s1 <= handle_pool;
			hslot_s1 <= handle_slot;
			hver_s1  <= handle_version;
		end
	end

	// Handle check and the slot entry as seen past the fresh-slot boundary.
	always_comb begin
		handle_good = (hpool_s1 == pool_id_q) &&
			!(hpool_s1 == '0 && hslot_s1 == '0 && hver_s1 == '0) &&
			(32'(hslot_s1) < SLOTS);
		entry_touched  = 32'(hslot_s1) < 32'(next_fresh_q);
		cur_live       = entry_touched && slot_rd_data.live;
		cur_version    = entry_touched ? slot_rd_data.version : '0;
		bumped_version = cur_version + VER_W'(1);
		if (bumped_version == '0) begin
			bumped_version = VER_W'(1);
		end
		product = (ESIZE_W+HSLOT_W)'(hslot_s1) * (ESIZE_W+HSLOT_W)'(element_size_q);
	end

	// Operation logic: result fields, memory writes and next counter values.
	always_comb begin
		res_ok       = 1'b0;
		res_slot     = hslot_s1;
		res_version  = '0;
		res_pool     = '0;
		res_address  = '0;
		live_next    = in_use_q;
		free_next    = free_top_q;
		fresh_next   = next_fresh_q;
		slot_wr_en   = 1'b0;
		slot_wr_addr = SW'(hslot_s1);
		slot_wr_data = '{version: bumped_version, live: 1'b0};
		stk_wr_en    = 1'b0;
		stk_wr_addr  = SW'(free_top_q);
		stk_wr_data  = {bumped_version, SW'(hslot_s1)};
		case (kind_s1)
			KIND_ALLOC: begin
				res_slot = '0;
				if (32'(next_fresh_q) < SLOTS) begin
					// Never-used slot: its version goes from zero to one.
					res_ok       = 1'b1;
					res_slot     = HSLOT_W'(next_fresh_q);
					res_version  = VER_W'(1);
					slot_wr_en   = 1'b1;
					slot_wr_addr = SW'(next_fresh_q);
					fresh_next   = next_fresh_q + CW'(1);
				end else if (free_top_q != '0) begin
					// Popped slot keeps the version it got when freed.
					res_ok       = 1'b1;
					res_slot     = HSLOT_W'(stk_rd_data[SW-1:0]);
					res_version  = stk_rd_data[STK_W-1 -: VER_W];
					slot_wr_en   = 1'b1;
					slot_wr_addr = stk_rd_data[SW-1:0];
					free_next    = free_top_q - CW'(1);
				end
				if (res_ok) begin
					res_pool     = pool_id_q;
					slot_wr_data = '{version: res_version, live: 1'b1};
					live_next    = in_use_q + CW'(1);
				end
			end
			KIND_FREE: begin
				if (handle_good && cur_live) begin
					res_ok     = 1'b1;
					slot_wr_en = 1'b1;
					if (32'(free_top_q) < SLOTS) begin
						stk_wr_en = 1'b1;
						free_next = free_top_q + CW'(1);
					end
					if (in_use_q != '0) begin
						live_next = in_use_q - CW'(1);
					end
				end
			end
			KIND_LOOKUP: begin
				if (handle_good) begin
					res_ok      = 1'b1;
					res_address = product[ADDR_W-1:0];
				end
			end
			default: ;
		endcase
		// Memories and counters change only when the item completes.
		if (!done_s1) begin
			slot_wr_en = 1'b0;
			stk_wr_en  = 1'b0;
		end
	end

	// Counter update at completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_fresh_q <= '0;
			free_top_q   <= '0;
			in_use_q     <= '0;
		end else if (done_s1) begin
			next_fresh_q <= fresh_next;
			free_top_q   <= free_next;
			in_use_q     <= live_next;
		end
	end

	// Output register: loads on completion, clears when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			ok_q       <= res_ok;
			slot_q     <= res_slot;
			version_q  <= res_version;
			pool_q     <= res_pool;
			address_q  <= res_address;
			live_count <= CNT_W'(live_next);
			free_count <= CNT_W'(free_next);
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign slot      = slot_q;
	assign version   = version_q;
	assign pool      = pool_q;
	assign address   = address_q;

endmodule

`default_nettype wire

[design/ghp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ghp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
